// ===== rtl/rgbw_pkg.sv =====
// Package for the RGB to RGBW white extraction block.
// Holds the strip type codes, the white point and reciprocal tables, and the
// small multiply helper. Used by rgbw_pipe and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rgbw_pkg;

  // Strip type codes held in the configuration register
  typedef enum logic [2:0] {
    STRIP_RGB    = 3'd0,
    STRIP_6000K  = 3'd1,
    STRIP_4000K  = 3'd2,
    STRIP_3000K  = 3'd3,
    STRIP_RGB_NW = 3'd4
  } strip_e;

  // Register index of the strip type register
  localparam logic REG_STRIP_TYPE = 1'b0;

  // Red component of every white point
  localparam logic [7:0] RED_POINT = 8'd255;

  // Shift of the fixed-point reciprocals: ceil(2^24 / d)
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = 16 + RECIP_W;

  // Green and blue components of the white LED colour point, plus a passthrough flag
  typedef struct packed {
    logic       pass;
    logic [7:0] grn;
    logic [7:0] blu;
  } point_t;

  function automatic point_t white_point(input logic [2:0] st);
    point_t p;
    p.pass = 1'b0;
    p.grn  = 8'd255;
    p.blu  = 8'd255;
    case (st)
      STRIP_6000K: begin
        p.grn = 8'd243;
        p.blu = 8'd239;
      end
      STRIP_4000K: begin
        p.grn = 8'd209;
        p.blu = 8'd163;
      end
      STRIP_3000K: begin
        p.grn = 8'd180;
        p.blu = 8'd107;
      end
      default: begin
        p.pass = 1'b1;
      end
    endcase
    return p;
  endfunction

  // Reciprocal ceil(2^24 / d); exact floor division for n < 2^16, d < 2^8
  function automatic logic [RECIP_W-1:0] recip(input logic [7:0] d);
    logic [RECIP_W-1:0] r;
    r = '0;
    case (d)
      8'd255: r = 18'd65794;
      8'd243: r = 18'd69043;
      8'd239: r = 18'd70198;
      8'd209: r = 18'd80274;
      8'd163: r = 18'd102928;
      8'd180: r = 18'd93207;
      8'd107: r = 18'd156797;
      default: r = '0;
    endcase
    return r;
  endfunction

  // 8 x 8 unsigned product
  function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
    return 16'(a) * 16'(b);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbw_pipe.sv =====
// Five stage datapath of the RGB to RGBW converter with valid/stall flow.
// Depends on rgbw_pkg for white points, reciprocals and the multiply helper.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_pipe (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [2:0]  strip_type_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       white_out_o
);
  import rgbw_pkg::*;

  // Stage valids and enables; a stage loads when empty or when its successor moves
  logic [4:0] vld_q;
  logic [4:0] en;

  always_comb begin
    en[4] = !vld_q[4] || !out_stall_i;
    en[3] = !vld_q[3] || en[4];
    en[2] = !vld_q[2] || en[3];
    en[1] = !vld_q[1] || en[2];
    en[0] = !vld_q[0] || en[1];
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      if (en[4]) vld_q[4] <= vld_q[3];
    end
  end

  // Stage 1: look up the white point, form the cross products
  point_t     pt;
  logic [7:0] s1_c_q [3];
  logic [7:0] s1_dg_q, s1_db_q;
  logic       s1_pass_q;
  logic [15:0] s1_c1d0_q, s1_c0d1_q, s1_c2d0_q, s1_c0d2_q, s1_c2d1_q, s1_c1d2_q;

  assign pt = white_point(strip_type_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_c_q[0] <= red_in_i;
      s1_c_q[1] <= green_in_i;
      s1_c_q[2] <= blue_in_i;
      s1_dg_q   <= pt.grn;
      s1_db_q   <= pt.blu;
      s1_pass_q <= pt.pass;
      s1_c1d0_q <= mul8(green_in_i, RED_POINT);
      s1_c0d1_q <= mul8(red_in_i, pt.grn);
      s1_c2d0_q <= mul8(blue_in_i, RED_POINT);
      s1_c0d2_q <= mul8(red_in_i, pt.blu);
      s1_c2d1_q <= mul8(blue_in_i, pt.grn);
      s1_c1d2_q <= mul8(green_in_i, pt.blu);
    end
  end

  // Stage 2: pick the channel with the smallest needed white level
  logic       k1, k2;
  logic [7:0] ck_d, dk_d;
  logic [7:0] s2_c_q [3];
  logic [7:0] s2_dg_q, s2_db_q, s2_ck_q, s2_dk_q;
  logic       s2_pass_q;

  always_comb begin
    k1 = s1_c1d0_q < s1_c0d1_q;
    k2 = k1 ? (s1_c2d1_q < s1_c1d2_q) : (s1_c2d0_q < s1_c0d2_q);
    if (k2) begin
      ck_d = s1_c_q[2];
      dk_d = s1_db_q;
    end else if (k1) begin
      ck_d = s1_c_q[1];
      dk_d = s1_dg_q;
    end else begin
      ck_d = s1_c_q[0];
      dk_d = RED_POINT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_c_q    <= s1_c_q;
      s2_dg_q   <= s1_dg_q;
      s2_db_q   <= s1_db_q;
      s2_ck_q   <= ck_d;
      s2_dk_q   <= dk_d;
      s2_pass_q <= s1_pass_q;
    end
  end

  // Stage 3: residual numerators c_j*d_k - c_k*d_j, white numerator, reciprocal
  logic [15:0]        s3_num_q [4];
  logic [RECIP_W-1:0] s3_rcp_q;
  logic [7:0]         s3_c_q [3];
  logic               s3_pass_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_num_q[0] <= mul8(s2_c_q[0], s2_dk_q) - mul8(s2_ck_q, RED_POINT);
      s3_num_q[1] <= mul8(s2_c_q[1], s2_dk_q) - mul8(s2_ck_q, s2_dg_q);
      s3_num_q[2] <= mul8(s2_c_q[2], s2_dk_q) - mul8(s2_ck_q, s2_db_q);
      s3_num_q[3] <= mul8(s2_ck_q, RED_POINT);
      s3_rcp_q    <= recip(s2_dk_q);
      s3_c_q      <= s2_c_q;
      s3_pass_q   <= s2_pass_q;
    end
  end

  // Stage 4: divide by d_k as a multiply by its reciprocal
  logic [PROD_W-1:0] s4_prod_q [4];
  logic [7:0]        s4_c_q [3];
  logic              s4_pass_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        s4_prod_q[i] <= PROD_W'(s3_num_q[i]) * PROD_W'(s3_rcp_q);
      end
      s4_c_q    <= s3_c_q;
      s4_pass_q <= s3_pass_q;
    end
  end

  // Stage 5: output register; passthrough types bypass the white removal
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      if (s4_pass_q) begin
        red_out_o   <= s4_c_q[0];
        green_out_o <= s4_c_q[1];
        blue_out_o  <= s4_c_q[2];
        white_out_o <= '0;
      end else begin
        red_out_o   <= s4_prod_q[0][RECIP_SHIFT+7:RECIP_SHIFT];
        green_out_o <= s4_prod_q[1][RECIP_SHIFT+7:RECIP_SHIFT];
        blue_out_o  <= s4_prod_q[2][RECIP_SHIFT+7:RECIP_SHIFT];
        white_out_o <= s4_prod_q[3][RECIP_SHIFT+7:RECIP_SHIFT];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_rgbw_white_extract.sv =====
// RGB pixels in, RGBW LED drive words out, one word per cycle while the output
// is not stalled. The strip type register (APB, byte address 0) picks the white
// LED colour point: 6000K, 4000K or 3000K; other codes pass RGB through with
// white at 0. Throughput is one pixel per clock, set by the pipelined 8x8
// products and the 16x18 reciprocal multiply that replaces the division by
// the white point component. A stall at the output holds the pipe, while
// empty stages keep filling. Write the strip type only while the block is idle.
// Depends on rgbw_pkg and rgbw_pipe.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_rgbw_white_extract (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pixel input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  // drive output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       white_out_o
);
  import rgbw_pkg::*;

  logic [2:0] strip_q, strip_d;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == REG_STRIP_TYPE;

  // Strip type register write
  always_comb begin
    strip_d = strip_q;
    if (psel && penable && pwrite && reg_sel) begin
      strip_d = pwdata[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= STRIP_RGB;
    end else begin
      strip_q <= strip_d;
    end
  end

  // Read back
  assign prdata = reg_sel ? {29'd0, strip_q} : 32'd0;

  rgbw_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .strip_type_i (strip_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .white_out_o  (white_out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rgbw_chk.sv =====
// Port-level checks for the RGB to RGBW converter, bound to the top level.
// Sees only the top-level ports; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  red_out_o,
  input wire logic [7:0]  green_out_o,
  input wire logic [7:0]  blue_out_o,
  input wire logic [7:0]  white_out_o
);

  // A stalled output word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_out_o) && $stable(green_out_o) &&
      $stable(blue_out_o) && $stable(white_out_o))
    else $error("output word changed while stalled");

  // Input is only held off when the output side is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipe");

  // Whenever white is driven, the limiting colour channel is fully removed
  a_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (white_out_o != 8'd0) |->
      (red_out_o == 8'd0) || (green_out_o == 8'd0) || (blue_out_o == 8'd0))
    else $error("white driven with no colour channel at zero");

endmodule

bind rgb_to_rgbw_white_extract rgbw_chk u_rgbw_chk (.*);

`default_nettype wire
